// ===== rtl/lbp_pkg.sv =====
// Shared types and constants for the 3x3 LBP pixel stream unit.
// No dependencies.
`default_nettype none

package lbp_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int PIX_W     = 8;
  localparam int FW_W      = 11;
  localparam int FH_W      = 12;
  localparam int OIDX_W    = 22;
  localparam int TOT_W     = FW_W + FH_W;
  localparam int WIN_N     = 6;

  typedef enum logic [0:0] {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;

  // neighbor bit: set only when strictly greater than the center
  function automatic logic nb_bit(input pix_t nb, input pix_t ctr);
    return (nb > ctr);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lbp_3x3_pixel_stream_unit.sv =====
// 3x3 local binary pattern over a raster gray pixel stream.
// Depends on lbp_pkg.
//
//  channel | ports                                | payload
//  in      | in_valid / in_ready                  | in_command, in_pixel
//  out     | out_valid / out_ready                | out_code, out_frame_end
//  cfg     | cfg_valid / cfg_ready (always high)  | cfg_index, cfg_data
//
// One item per clock while not stalled. An accepted item reads the line store at its
// accepting edge; the line-store stage then forms the code and writes the store back,
// and the result enters the output register when that stage advances.
// Stalls: input waits only while the line-store stage holds a result and the
// output register is full and not being taken.
// Reset (rst_n low, synchronous) clears counters and the window; the line
// store needs no clearing pass.
`default_nettype none

module lbp_3x3_pixel_stream_unit (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [0:0]                   in_command,
  input  wire  [lbp_pkg::PIX_W-1:0]    in_pixel,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [lbp_pkg::PIX_W-1:0]    out_code,
  output logic                         out_frame_end,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [0:0]                   cfg_index,
  input  wire  [lbp_pkg::FH_W-1:0]     cfg_data
);
  import lbp_pkg::*;

  // configuration
  logic [FW_W-1:0]   fw_r;
  logic [FH_W-1:0]   fh_r;
  logic [FW_W-1:0]   w_eff;
  logic [FH_W-1:0]   h_eff;
  logic [TOT_W-1:0]  total;

  // input-side counters
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [FH_W-1:0]   row_r, row_nxt;
  logic [OIDX_W-1:0] oidx_r, oidx_nxt;
  logic [FW_W-1:0]   col_inc;
  logic [OIDX_W-1:0] oidx_inc;

  // line-store stage
  logic              s1_valid_r;
  logic              s1_pix_r;
  logic              s1_res_r;
  logic              s1_brd_r;
  logic              s1_fe_r;
  logic [COL_W-1:0]  s1_col_r;
  pix_t              s1_pixel_r;
  logic              s1_adv;
  logic              s1_load;
  logic              take_pix;
  logic              res_nxt;
  logic              brd_nxt;
  logic              fe_nxt;

  // line store {upper, middle}
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q_r;
  logic [2*PIX_W-1:0] byp_q_r;
  logic               byp_hit_r;
  logic [2*PIX_W-1:0] rd_data;
  logic               wr_en;
  logic [2*PIX_W-1:0] wr_data;
  pix_t               top;
  pix_t               mid;

  pix_t              win_r [WIN_N];
  pix_t              code;
  pix_t              ctr;

  logic              out_valid_r;
  pix_t              out_code_r;
  logic              out_fe_r;
  logic              acc;
  cmd_t              cmd;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FW_W'(256);
      fh_r <= FH_W'(256);
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FRAME_WIDTH:  fw_r <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: fh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (fw_r == '0)               w_eff = FW_W'(1);
    else if (fw_r > FW_W'(MAX_WIDTH))      w_eff = FW_W'(MAX_WIDTH);
    else                                   w_eff = fw_r;
    h_eff = (fh_r == '0) ? FH_W'(1) : fh_r;
    total = TOT_W'(w_eff) * TOT_W'(h_eff);
  end

  // ---------------- input side ----------------
  assign acc      = in_valid && in_ready;
  assign cmd      = cmd_t'(in_command);
  assign col_inc  = FW_W'(col_r) + FW_W'(1);
  assign oidx_inc = oidx_r + OIDX_W'(1);
  assign fe_nxt   = (TOT_W'(oidx_r) == total - TOT_W'(1));
  assign take_pix = acc && (cmd == CMD_PIXEL) && (row_r < h_eff);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    oidx_nxt = oidx_r;
    res_nxt  = 1'b0;
    s1_load  = 1'b0;
    brd_nxt  = (col_r >= COL_W'(2)) && (row_r >= FH_W'(2)) &&
               ((w_eff == FW_W'(1)) || (FW_W'(col_r) < w_eff));
    if (acc) begin
      unique case (cmd)
        CMD_PIXEL: begin
          if (row_r < h_eff) begin
            s1_load = 1'b1;
            res_nxt = (row_r >= FH_W'(2)) ||
                      ((row_r == FH_W'(1)) && (col_r != '0)) ||
                      ((row_r == '0) && (FW_W'(col_r) >= w_eff + FW_W'(1)));
            if (res_nxt) oidx_nxt = oidx_inc;
            if (col_inc >= w_eff) begin
              col_nxt = '0;
              row_nxt = row_r + FH_W'(1);
            end else begin
              col_nxt = col_inc[COL_W-1:0];
            end
          end
        end
        CMD_FLUSH: begin
          if (row_r >= h_eff) begin
            if (TOT_W'(oidx_r) >= total) begin
              col_nxt  = '0;
              row_nxt  = '0;
              oidx_nxt = '0;
            end else begin
              s1_load = 1'b1;
              res_nxt = 1'b1;
              if (TOT_W'(oidx_inc) >= total) begin
                col_nxt  = '0;
                row_nxt  = '0;
                oidx_nxt = '0;
              end else begin
                oidx_nxt = oidx_inc;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      oidx_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      oidx_r <= oidx_nxt;
    end
  end

  // ---------------- line-store stage ----------------
  assign s1_adv   = s1_valid_r && (!s1_res_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_pix_r   <= (cmd == CMD_PIXEL);
      s1_res_r   <= res_nxt;
      s1_brd_r   <= brd_nxt && (cmd == CMD_PIXEL);
      s1_fe_r    <= fe_nxt;
      s1_col_r   <= col_r;
      s1_pixel_r <= in_pixel;
    end
  end

  assign rd_data = byp_hit_r ? byp_q_r : rd_q_r;
  assign top     = rd_data[2*PIX_W-1:PIX_W];
  assign mid     = rd_data[PIX_W-1:0];
  assign wr_en   = s1_adv && s1_pix_r;
  assign wr_data = {mid, s1_pixel_r};

  always_ff @(posedge clk) begin
    if (wr_en) line_mem[s1_col_r] <= wr_data;
    if (take_pix) rd_q_r <= line_mem[col_r];
  end

  // same-entry write in the read cycle: forward the new data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else if (take_pix) begin
      byp_hit_r <= wr_en && (s1_col_r == col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (take_pix) byp_q_r <= wr_data;
  end

  // window: [0..2] column c-1 top/mid/bottom, [3..5] column c-2
  assign ctr = win_r[1];

  always_comb begin
    code = '0;
    if (s1_brd_r) begin
      code[0] = nb_bit(win_r[3], ctr);
      code[1] = nb_bit(win_r[0], ctr);
      code[2] = nb_bit(top, ctr);
      code[3] = nb_bit(win_r[4], ctr);
      code[4] = nb_bit(mid, ctr);
      code[5] = nb_bit(win_r[5], ctr);
      code[6] = nb_bit(win_r[2], ctr);
      code[7] = nb_bit(s1_pixel_r, ctr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_N; i++) win_r[i] <= '0;
    end else if (wr_en) begin
      win_r[3] <= win_r[0];
      win_r[4] <= win_r[1];
      win_r[5] <= win_r[2];
      win_r[0] <= top;
      win_r[1] <= mid;
      win_r[2] <= s1_pixel_r;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_res_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_res_r) begin
      out_code_r <= code;
      out_fe_r   <= s1_fe_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_code      = out_code_r;
  assign out_frame_end = out_fe_r;

  // ---------------- assertions ----------------
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_res_r && out_valid_r && !out_ready |-> !s1_adv && !in_ready)
    else $error("result would overwrite a pending output item");

  a_s1_useful: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> s1_pix_r || s1_res_r)
    else $error("ignored item entered the line-store stage");

  a_flush_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_pix_r |-> !s1_brd_r && code == '0)
    else $error("flush item carries a nonzero code");

  a_brd_col: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_brd_r |-> s1_col_r >= COL_W'(2))
    else $error("interior code formed in the first two columns");

  a_byp_pix: assert property (@(posedge clk) disable iff (!rst_n)
    take_pix && wr_en && (s1_col_r == col_r) |=> byp_hit_r && s1_pix_r)
    else $error("same-entry write not forwarded");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for lbp_3x3_pixel_stream_unit: raster frames of random
// size and content, with noise items, mid-frame size changes and random stalls.
// Depends on lbp_pkg and the unit; results are checked by a scoreboard class.
`default_nettype none

module tb_top;
  import lbp_pkg::*;

  localparam int          LIMIT_CYCLES = 400000;
  localparam int          WORK_ITEMS   = 1850;
  localparam int unsigned IDX_MASK     = (1 << OIDX_W) - 1;

  typedef struct packed {
    pix_t code;
    logic frame_end;
  } lbp_result_t;

  class lbp_scoreboard;
    logic [FW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;
    pix_t            upper[MAX_WIDTH];
    pix_t            middle[MAX_WIDTH];
    pix_t            win[WIN_N];
    int unsigned     col;
    int unsigned     row;
    int unsigned     out_idx;
    lbp_result_t     codes_q[$];
    int unsigned     mismatches;

    function new();
      width_reg  = FW_W'(256);
      height_reg = FH_W'(256);
      foreach (upper[i]) begin
        upper[i]  = '0;
        middle[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      restart();
      mismatches = 0;
    endfunction

    function void restart();
      col     = 0;
      row     = 0;
      out_idx = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return 32'(width_reg);
    endfunction

    function int unsigned eff_height();
      return (height_reg == 0) ? 1 : 32'(height_reg);
    endfunction

    function int unsigned frame_pixels();
      return eff_width() * eff_height();
    endfunction

    function bit in_tail();
      return row >= eff_height();
    endfunction

    function bit busy();
      return codes_q.size() != 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [FH_W-1:0] val);
      if (idx == REG_FRAME_WIDTH) width_reg = val[FW_W-1:0];
      else height_reg = val;
    endfunction

    // returns 1 when the item changed state (not ignored)
    function bit note_input(cmd_t cmd, pix_t pix);
      int unsigned w, h, total, c, r, lin, addr;
      pix_t        top, mid, ctr;
      lbp_result_t res;
      w     = eff_width();
      h     = eff_height();
      total = w * h;
      if (cmd == CMD_FLUSH) begin
        if (row < h) return 0;
        if (out_idx >= total) begin
          restart();
          return 1;
        end
        res.code      = '0;
        res.frame_end = (out_idx == total - 1);
        codes_q.insert(codes_q.size(), res);
        out_idx = (out_idx + 1) & IDX_MASK;
        if (out_idx >= total) restart();
        return 1;
      end
      if (row >= h) return 0;
      c        = col;
      r        = row;
      lin      = r * w + c;
      addr     = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
      top      = upper[addr];
      mid      = middle[addr];
      res.code = '0;
      if (c >= 2 && r >= 2 && r - 1 <= h - 2 && c - 1 <= w - 2) begin
        ctr         = win[1];
        res.code[0] = win[3] > ctr;
        res.code[1] = win[0] > ctr;
        res.code[2] = top > ctr;
        res.code[3] = win[4] > ctr;
        res.code[4] = mid > ctr;
        res.code[5] = win[5] > ctr;
        res.code[6] = win[2] > ctr;
        res.code[7] = pix > ctr;
      end
      if (lin >= w + 1) begin
        res.frame_end = (out_idx == total - 1);
        codes_q.insert(codes_q.size(), res);
        out_idx = (out_idx + 1) & IDX_MASK;
      end
      win[3]       = win[0];
      win[4]       = win[1];
      win[5]       = win[2];
      win[0]       = top;
      win[1]       = mid;
      win[2]       = pix;
      upper[addr]  = mid;
      middle[addr] = pix;
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      col = c;
      row = r;
      return 1;
    endfunction

    function void check_result(pix_t code, logic frame_end);
      lbp_result_t exp_res;
      if (codes_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: code %0d frame_end %0b", code, frame_end);
        return;
      end
      exp_res = codes_q.pop_front();
      if (exp_res.code !== code || exp_res.frame_end !== frame_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: code exp %0d got %0d, frame_end exp %0b got %0b",
                   exp_res.code, code, exp_res.frame_end, frame_end);
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  logic [0:0]      in_command;
  pix_t            in_pixel;
  logic            out_valid;
  logic            out_ready = 1'b0;
  pix_t            out_code;
  logic            out_frame_end;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [0:0]      cfg_index;
  logic [FH_W-1:0] cfg_data;

  lbp_scoreboard   sb;
  bit              calm;
  int              work;
  int              cycles = 0;
  pix_t            base_level;

  lbp_3x3_pixel_stream_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_pixel     (in_pixel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_code     (out_code),
    .out_frame_end(out_frame_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
  end

  // handshake seen at the falling edge is taken at the next rising edge
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_code, out_frame_end);
  end

  task automatic send_item(input cmd_t cmd, input pix_t pix);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_pixel   <= pix;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    if (sb.note_input(cmd, pix)) work++;
    @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [FH_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    sb.set_reg(idx, val);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.busy()) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic pix_t pick_pixel(input int mode);
    case (mode)
      0: return pix_t'($urandom);
      1: return base_level + pix_t'($urandom_range(2));
      2: return $urandom_range(1) ? 8'hFF : 8'h00;
      default: return $urandom_range(1) ? pix_t'($urandom) : base_level;
    endcase
  endfunction

  // complete the frame, then drain its pending codes
  task automatic finish_frame(input int mode);
    while (!sb.in_tail()) send_item(CMD_PIXEL, pick_pixel(mode));
    while (sb.in_tail()) send_item(CMD_FLUSH, pix_t'($urandom));
  endtask

  initial begin
    pix_t            grid_a[9];
    pix_t            grid_b[9];
    int              frames;
    int              mode;
    int              npix;
    int              cut;
    bit              broken;
    logic [FH_W-1:0] w_val;
    logic [FH_W-1:0] h_val;

    sb         = new();
    calm       = 1'b0;
    work       = 0;
    base_level = '0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_command <= CMD_PIXEL;
    in_pixel   <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_FRAME_WIDTH;
    cfg_data   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all neighbors above the center, with a flush inside the frame and a pixel after it
    grid_a = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255};
    grid_b = '{8'd129, 8'd128, 8'd255, 8'd0, 8'd128, 8'd200, 8'd128, 8'd127, 8'd129};
    write_reg(REG_FRAME_WIDTH, 12'd3);
    write_reg(REG_FRAME_HEIGHT, 12'd3);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_item(CMD_FLUSH, 8'hA5);
      send_item(CMD_PIXEL, grid_a[i]);
    end
    send_item(CMD_PIXEL, 8'h5A);
    finish_frame(0);
    // equal, lower and higher neighbors around one center
    for (int i = 0; i < 9; i++) send_item(CMD_PIXEL, grid_b[i]);
    finish_frame(0);
    wait_idle();
    // zero sizes act as 1x1
    write_reg(REG_FRAME_WIDTH, 12'd0);
    write_reg(REG_FRAME_HEIGHT, 12'd0);
    send_item(CMD_PIXEL, 8'd77);
    finish_frame(0);
    wait_idle();

    // width saturates at the line store depth; shrink the frame mid-way so nothing is pending
    write_reg(REG_FRAME_WIDTH, 12'hFFF);
    write_reg(REG_FRAME_HEIGHT, 12'hFFF);
    repeat (MAX_WIDTH + 4) send_item(CMD_PIXEL, pix_t'($urandom));
    wait_idle();
    write_reg(REG_FRAME_HEIGHT, 12'd0);
    write_reg(REG_FRAME_WIDTH, 12'd0);
    finish_frame(0);
    wait_idle();

    frames = 0;
    while (work < WORK_ITEMS) begin
      case ($urandom_range(9))
        0: w_val = FH_W'($urandom_range(1, 3));
        1: w_val = '0;
        default: w_val = FH_W'($urandom_range(3, 24));
      endcase
      case ($urandom_range(9))
        0: h_val = FH_W'($urandom_range(1, 2));
        1: h_val = '0;
        default: h_val = FH_W'($urandom_range(3, 10));
      endcase
      write_reg(REG_FRAME_WIDTH, w_val);
      write_reg(REG_FRAME_HEIGHT, h_val);
      calm       = (frames >= 1 && frames < 5);
      mode       = $urandom_range(3);
      base_level = pix_t'($urandom);
      npix       = sb.frame_pixels();
      broken     = ($urandom_range(5) == 0);
      cut        = broken ? $urandom_range(npix - 1) : npix;
      for (int i = 0; i < cut; i++) begin
        if ($urandom_range(19) == 0) send_item(CMD_FLUSH, pix_t'($urandom));
        send_item(CMD_PIXEL, pick_pixel(mode));
      end
      if (broken) begin
        wait_idle();
        if ($urandom_range(1))
          write_reg(REG_FRAME_HEIGHT, FH_W'($urandom_range(sb.row + 1)));
        else
          write_reg(REG_FRAME_WIDTH, FH_W'($urandom_range(sb.eff_width())));
      end else if ($urandom_range(2) == 0) begin
        repeat ($urandom_range(1, 2)) send_item(CMD_PIXEL, pix_t'($urandom));
      end
      finish_frame(mode);
      if ($urandom_range(4) == 0) send_item(CMD_FLUSH, pix_t'($urandom));
      wait_idle();
      frames++;
    end

    calm = 1'b0;
    wait_idle();
    if (sb.mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
